// ===== design/srl_pkg.sv =====
`default_nettype none
package srl_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic signed [31:0] id;
		logic [7:0]         age;
		logic [31:0]        salary;
		logic [7:0]         letter;
	} record_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic [7:0]         position;
		logic signed [31:0] record_id;
		logic [7:0]         record_age;
		logic [31:0]        salary_key;
		logic [7:0]         contract_letter;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [4:0]         entry_count;
		logic signed [31:0] read_id;
		logic [7:0]         read_age;
		logic [31:0]        read_salary;
		logic [7:0]         read_letter;
	} rsp_t;

	typedef struct packed {
		logic             we;
		logic             wsel_new;
		logic [IDX_W-1:0] waddr;
		logic [IDX_W-1:0] raddr;
		logic             first;
	} store_ctl_t;

endpackage
`default_nettype wire

// ===== design/srl_store.sv =====
`default_nettype none
module srl_store
	import srl_pkg::*;
(
	input  wire logic       clk,
	input  wire store_ctl_t ctl,
	input  wire record_t    rec,
	output record_t         rdata,
	output logic            stop
);

	record_t mem [DEPTH];
	record_t rdata_q;
	logic [31:0] cmp_a;
	logic [31:0] cmp_b;
	logic        lt;

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[ctl.waddr] <= ctl.wsel_new ? rec : rdata_q;
		end
		rdata_q <= mem[ctl.raddr];
	end

	// one comparator; operands swap for the head entry, where equal keys go after
	always_comb begin
		cmp_a = ctl.first ? rec.salary : rdata_q.salary;
		cmp_b = ctl.first ? rdata_q.salary : rec.salary;
		lt    = cmp_a < cmp_b;
		stop  = ctl.first ? lt : !lt;
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== design/srl_ctrl.sv =====
`default_nettype none
module srl_ctrl
	import srl_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire cmd_t    cmd,
	input  wire record_t rdata,
	input  wire logic    stop,
	output logic         busy,
	output store_ctl_t   ctl,
	output record_t      rec,
	output logic         done,
	output rsp_t         result
);

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_SRCH_RD  = 7'b0000010,
		S_SRCH_CMP = 7'b0000100,
		S_SHF_RD   = 7'b0001000,
		S_SHF_WR   = 7'b0010000,
		S_PLACE    = 7'b0100000,
		S_READ_OUT = 7'b1000000
	} state_t;

	state_t           state_q, state_d;
	op_t              op_q, op_d;
	record_t          rec_q, rec_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] k_q, k_d;
	logic [CNT_W-1:0] slot_q, slot_d;
	logic             done_q;
	rsp_t             rsp_q;

	logic             fin;
	logic [1:0]       fin_status;
	logic [CNT_W-1:0] fin_cnt;
	record_t          fin_rec;
	logic             accept;
	logic             full;
	logic             out_of_range;

	assign accept       = start && (state_q == S_IDLE);
	assign full         = cnt_q == CNT_W'(DEPTH);
	assign out_of_range = {1'b0, cmd.position} >= 9'(cnt_q);

	always_comb begin
		state_d    = state_q;
		op_d       = op_q;
		rec_d      = rec_q;
		cnt_d      = cnt_q;
		k_d        = k_q;
		slot_d     = slot_q;
		fin        = 1'b0;
		fin_status = ST_DONE;
		fin_cnt    = cnt_q;
		fin_rec    = '0;
		ctl.we       = 1'b0;
		ctl.wsel_new = 1'b0;
		ctl.waddr    = k_q[IDX_W-1:0];
		ctl.raddr    = k_q[IDX_W-1:0];
		ctl.first    = k_q == '0;

		case (state_q)
			S_IDLE: begin
				ctl.raddr = cmd.position[IDX_W-1:0];
				if (accept) begin
					op_d  = op_t'(cmd.operation);
					rec_d = '{id: cmd.record_id, age: cmd.record_age,
						salary: cmd.salary_key, letter: cmd.contract_letter};
					case (op_t'(cmd.operation))
						OP_APPEND, OP_INSERT: begin
							if (full) begin
								fin        = 1'b1;
								fin_status = ST_FULL;
							end else if (op_t'(cmd.operation) == OP_APPEND) begin
								slot_d  = cnt_q;
								state_d = S_PLACE;
							end else if (cnt_q == '0) begin
								slot_d  = '0;
								state_d = S_PLACE;
							end else begin
								k_d     = '0;
								state_d = S_SRCH_RD;
							end
						end
						OP_DELETE: begin
							if (out_of_range) begin
								fin        = 1'b1;
								fin_status = ST_RANGE;
							end else if (CNT_W'(cmd.position) + CNT_W'(1) == cnt_q) begin
								// tail entry: nothing to close up
								cnt_d   = cnt_q - CNT_W'(1);
								fin     = 1'b1;
								fin_cnt = cnt_q - CNT_W'(1);
							end else begin
								k_d     = CNT_W'(cmd.position);
								state_d = S_SHF_RD;
							end
						end
						OP_READ: begin
							if (out_of_range) begin
								fin        = 1'b1;
								fin_status = ST_RANGE;
							end else begin
								state_d = S_READ_OUT;
							end
						end
						default: ;
					endcase
				end
			end
			S_SRCH_RD: begin
				state_d = S_SRCH_CMP;
			end
			S_SRCH_CMP: begin
				if (stop) begin
					slot_d  = k_q;
					k_d     = cnt_q;
					state_d = S_SHF_RD;
				end else if (k_q + CNT_W'(1) == cnt_q) begin
					slot_d  = cnt_q;
					state_d = S_PLACE;
				end else begin
					k_d     = k_q + CNT_W'(1);
					state_d = S_SRCH_RD;
				end
			end
			S_SHF_RD: begin
				if (op_q == OP_INSERT) begin
					ctl.raddr = IDX_W'(k_q - CNT_W'(1));
				end else begin
					ctl.raddr = IDX_W'(k_q + CNT_W'(1));
				end
				state_d = S_SHF_WR;
			end
			S_SHF_WR: begin
				ctl.we = 1'b1;
				if (op_q == OP_INSERT) begin
					k_d = k_q - CNT_W'(1);
					if (k_q - CNT_W'(1) == slot_q) begin
						state_d = S_PLACE;
					end else begin
						state_d = S_SHF_RD;
					end
				end else begin
					k_d = k_q + CNT_W'(1);
					if (k_q + CNT_W'(2) == cnt_q) begin
						cnt_d   = cnt_q - CNT_W'(1);
						fin     = 1'b1;
						fin_cnt = cnt_q - CNT_W'(1);
						state_d = S_IDLE;
					end else begin
						state_d = S_SHF_RD;
					end
				end
			end
			S_PLACE: begin
				ctl.we       = 1'b1;
				ctl.wsel_new = 1'b1;
				ctl.waddr    = slot_q[IDX_W-1:0];
				cnt_d        = cnt_q + CNT_W'(1);
				fin          = 1'b1;
				fin_cnt      = cnt_q + CNT_W'(1);
				state_d      = S_IDLE;
			end
			S_READ_OUT: begin
				fin     = 1'b1;
				fin_rec = rdata;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			done_q  <= fin;
		end
	end

	always_ff @(posedge clk) begin
		op_q   <= op_d;
		rec_q  <= rec_d;
		k_q    <= k_d;
		slot_q <= slot_d;
		if (fin) begin
			rsp_q.status      <= fin_status;
			rsp_q.entry_count <= 5'(fin_cnt);
			rsp_q.read_id     <= fin_rec.id;
			rsp_q.read_age    <= fin_rec.age;
			rsp_q.read_salary <= fin_rec.salary;
			rsp_q.read_letter <= fin_rec.letter;
		end
	end

	assign busy   = state_q != S_IDLE;
	assign rec    = rec_q;
	assign done   = done_q;
	assign result = rsp_q;

endmodule
`default_nettype wire

// ===== design/sorted_record_list_top.sv =====
// refused, out-of-range and tail-delete items are decided at acceptance; append goes to a place
// step, read to a read-out step; delete moves each later entry up by a read and a write step;
// insert probes entries by a read and a compare step, moves later entries down by a read and a
// write step, then places the record; one item at a time: busy stays high until the result is
// registered; results are strobed for one cycle on done; the receiver cannot stall
// reset clears the entry count and sequencer; the record store itself is not initialized
`default_nettype none
module sorted_record_list_top
	import srl_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire cmd_t cmd,
	output logic      busy,
	output logic      done,
	output rsp_t      result
);

	store_ctl_t ctl;
	record_t    rec;
	record_t    rdata;
	logic       stop;

	srl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.rdata  (rdata),
		.stop   (stop),
		.busy   (busy),
		.ctl    (ctl),
		.rec    (rec),
		.done   (done),
		.result (result)
	);

	srl_store u_store (
		.clk   (clk),
		.ctl   (ctl),
		.rec   (rec),
		.rdata (rdata),
		.stop  (stop)
	);

	// a result only ever follows a cycle of work
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) || $past(start))
		else $error("result without an accepted item");

	// failed items carry zero read fields
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != ST_DONE |->
		result.read_id == '0 && result.read_age == '0 &&
		result.read_salary == '0 && result.read_letter == '0)
		else $error("read fields not cleared on failed item");

	// an accepted item that does not finish at once holds busy
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("item accepted without work or result");

	// no new strobe while still working
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy || $past(!busy))
		else $error("result strobed during a running item");

endmodule
`default_nettype wire
